@@ rtl/core/hbcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbcd_pkg
// Types and constants shared by the hot code block directory modules.
// ----------------------------------------------------------------------------
package hbcd_pkg;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INVAL  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [31:0]        LINE_MASK     = 32'hFFFF_FFC0;
  localparam logic [31:0]        UNCACHED_BASE = 32'hA000_0000;
  localparam logic [31:0]        IDLE_LIMIT    = 32'd2000;
  localparam logic signed [10:0] PINNED_HITS   = -11'sd1000;
  localparam logic signed [10:0] HITS_MAX      = 11'sd1023;
  localparam logic signed [10:0] WEAK_LIMIT    = 11'sd2;
  localparam logic [9:0]         THR_RESET     = 10'd16;

  typedef enum logic [2:0] {
    ACT_UNCACHED    = 3'd0,
    ACT_MISS_KEPT   = 3'd1,
    ACT_MISS_REPL   = 3'd2,
    ACT_RUN         = 3'd3,
    ACT_COUNTED     = 3'd4,
    ACT_COMPILE_RUN = 3'd5,
    ACT_COMPILE_ERR = 3'd6,
    ACT_DONE        = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_LOOK,
    ST_INV,
    ST_CLR
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [4:0]  cpu_mode;
    logic [7:0]  space_id;
    logic        compile_ok;
  } in_item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] slot;
    logic       short_isa;
  } out_item_t;

  typedef struct packed {
    logic [4:0]         mode;
    logic [7:0]         space;
    logic signed [10:0] hits;
    logic               compiled;
    logic [31:0]        last_use;
  } info_t;

  typedef struct packed {
    logic addr_we;
    logic info_we;
  } mem_we_t;

endpackage

@@ rtl/core/hbcd_store.sv @@
// ----------------------------------------------------------------------------
// hbcd_store
// Directory storage: entry addresses and entry state in two memories that
// share one read index and one write index, with registered read data.
// ----------------------------------------------------------------------------
module hbcd_store #(
  parameter int ENTRIES = 256,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [31:0]          rd_addr,
  output hbcd_pkg::info_t      rd_info,
  input  hbcd_pkg::mem_we_t    wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [31:0]          wr_addr,
  input  hbcd_pkg::info_t      wr_info
);
  import hbcd_pkg::*;

  logic [31:0] addr_mem [ENTRIES];
  info_t       info_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en.addr_we) begin
      addr_mem[wr_idx] <= wr_addr;
    end
    if (wr_en.info_we) begin
      info_mem[wr_idx] <= wr_info;
    end
    rd_addr <= addr_mem[rd_idx];
    rd_info <= info_mem[rd_idx];
  end

endmodule

@@ rtl/core/hot_block_code_cache_directory_core.sv @@
// ----------------------------------------------------------------------------
// hot_block_code_cache_directory_core
// Direct-mapped directory of translated code blocks with hit counting,
// compile triggering, line invalidation and clear-all.
// ----------------------------------------------------------------------------
//  Channel   Ports                        Handshake
//  input     start, busy, in_item         taken when start is high, busy low
//  result    out_valid, out_item          one-cycle strobe, never stalled
//  config    cfg_wr_en, cfg_wr_data       written when cfg_wr_en is high
//
//  A lookup is one registered memory read followed by an update in ST_LOOK.
//  With a non-power-of-two ENTRIES the slot comes from a reciprocal multiply
//  and a subtract; ST_MOD registers the quotient, then the subtract drives the read.
//  Invalidate and clear each sweep every entry.
//  After reset a clearing pass over every entry runs with busy high.
//  Results cannot be stalled; each appears for one cycle.
// ----------------------------------------------------------------------------
module hot_block_code_cache_directory_core #(
  parameter int ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hbcd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output hbcd_pkg::out_item_t  out_item,
  input  logic                 cfg_wr_en,
  input  logic [9:0]           cfg_wr_data
);
  import hbcd_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SHIFT = 30 + IDX_W;
  localparam bit IS_POW2 = (ENTRIES == (1 << IDX_W));
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
  localparam logic [30:0] RECIP = RECIP_FULL[30:0];
  localparam logic [29:0] DIVISOR = 30'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [29:0]     quo_r, quo_nxt;
  logic            phase_r, phase_nxt;
  logic [IDX_W-1:0] swp_ptr_r, swp_ptr_nxt;
  logic            swp_done_r, swp_done_nxt;
  logic            pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [9:0]      thr_r, thr_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_addr;
  info_t            rd_info;
  mem_we_t          wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_addr;
  info_t            wr_info;

  logic [IDX_W-1:0]   in_idx;
  logic [29:0]        pc_word;
  logic [60:0]        quo_prod;
  logic [60:0]        quo_shr;
  logic [29:0]        mod_full;
  logic [31:0]        acc_inc;
  logic               uncached;
  logic               hit;
  logic signed [10:0] h_inc;
  logic               over;
  logic               replace;

  hbcd_store #(.ENTRIES(ENTRIES)) u_store (
    .clk    (clk),
    .rd_idx (rd_idx),
    .rd_addr(rd_addr),
    .rd_info(rd_info),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_addr(wr_addr),
    .wr_info(wr_info)
  );

  assign in_idx   = in_item.address[IDX_W+1:2];
  assign pc_word  = item_r.address[31:2];
  assign quo_prod = 61'(pc_word) * 61'(RECIP);
  assign quo_shr  = quo_prod >> SHIFT;
  assign mod_full = pc_word - (quo_r * DIVISOR);

  assign acc_inc  = acc_r + 32'd1;
  assign uncached = (item_r.address >= UNCACHED_BASE);
  assign hit      = (rd_addr == item_r.address) && (rd_info.mode == item_r.cpu_mode) &&
                    (rd_info.space == item_r.space_id);
  assign h_inc    = (!rd_info.hits[10] && (rd_info.hits != HITS_MAX)) ?
                    (rd_info.hits + 11'sd1) : rd_info.hits;
  assign over     = (h_inc > $signed({1'b0, thr_r}));
  assign replace  = (rd_info.hits < WEAK_LIMIT) || (rd_addr == 32'd0) ||
                    ((acc_inc - rd_info.last_use) > IDLE_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      swp_ptr_r   <= '0;
      swp_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      acc_r       <= '0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      swp_ptr_r   <= swp_ptr_nxt;
      swp_done_r  <= swp_done_nxt;
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    quo_r      <= quo_nxt;
    phase_r    <= phase_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    quo_nxt       = quo_r;
    phase_nxt     = phase_r;
    swp_ptr_nxt   = swp_ptr_r;
    swp_done_nxt  = swp_done_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    acc_nxt       = acc_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    rd_idx  = in_idx;
    wr_en   = '0;
    wr_idx  = idx_r;
    wr_addr = item_r.address;
    wr_info = '{mode: rd_info.mode, space: rd_info.space, hits: rd_info.hits,
                compiled: rd_info.compiled, last_use: acc_inc};

    unique case (state_r)
      ST_INIT: begin
        wr_en   = '{addr_we: 1'b1, info_we: 1'b1};
        wr_idx  = swp_ptr_r;
        wr_addr = '0;
        wr_info = '0;
        swp_ptr_nxt = swp_ptr_r + IDX_W'(1);
        if (swp_ptr_r == LAST_IDX) begin
          swp_ptr_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          case (in_item.kind)
            KIND_LOOKUP: begin
              if (IS_POW2) begin
                idx_nxt   = in_idx;
                state_nxt = ST_LOOK;
              end else begin
                phase_nxt = 1'b0;
                state_nxt = ST_MOD;
              end
            end
            KIND_INVAL: begin
              swp_ptr_nxt  = '0;
              swp_done_nxt = 1'b0;
              pend_nxt     = 1'b0;
              state_nxt    = ST_INV;
            end
            KIND_CLEAR: begin
              acc_nxt     = '0;
              swp_ptr_nxt = '0;
              state_nxt   = ST_CLR;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{action: ACT_DONE, slot: 8'd0, short_isa: 1'b0};
            end
          endcase
        end
      end
      ST_MOD: begin
        if (!phase_r) begin
          quo_nxt   = quo_shr[29:0];
          phase_nxt = 1'b1;
        end else begin
          idx_nxt   = mod_full[IDX_W-1:0];
          rd_idx    = mod_full[IDX_W-1:0];
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        acc_nxt       = acc_inc;
        out_valid_nxt = 1'b1;
        out_item_nxt.slot      = 8'(idx_r);
        out_item_nxt.short_isa = item_r.address[0];
        state_nxt     = ST_IDLE;
        if (uncached) begin
          out_item_nxt.action = ACT_UNCACHED;
        end else if (hit) begin
          wr_en.info_we = 1'b1;
          if (rd_info.compiled) begin
            out_item_nxt.action = ACT_RUN;
          end else if (over) begin
            if (item_r.compile_ok) begin
              wr_info.hits        = h_inc;
              wr_info.compiled    = 1'b1;
              out_item_nxt.action = ACT_COMPILE_RUN;
            end else begin
              wr_info.hits        = PINNED_HITS;
              out_item_nxt.action = ACT_COMPILE_ERR;
            end
          end else begin
            wr_info.hits        = h_inc;
            out_item_nxt.action = ACT_COUNTED;
          end
        end else if (replace) begin
          wr_en   = '{addr_we: 1'b1, info_we: 1'b1};
          wr_info = '{mode: item_r.cpu_mode, space: item_r.space_id, hits: 11'sd1,
                      compiled: 1'b0, last_use: acc_inc};
          out_item_nxt.action = ACT_MISS_REPL;
        end else begin
          out_item_nxt.action = ACT_MISS_KEPT;
        end
      end
      ST_INV: begin
        rd_idx = swp_ptr_r;
        if (!swp_done_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = swp_ptr_r;
          if (swp_ptr_r == LAST_IDX) begin
            swp_done_nxt = 1'b1;
          end else begin
            swp_ptr_nxt = swp_ptr_r + IDX_W'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          wr_idx        = pend_idx_r;
          wr_addr       = '0;
          wr_en.addr_we = ((rd_addr & LINE_MASK) == (item_r.address & LINE_MASK));
        end
        if (swp_done_r && pend_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{action: ACT_DONE, slot: 8'd0, short_isa: 1'b0};
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLR: begin
        wr_en.addr_we = 1'b1;
        wr_idx        = swp_ptr_r;
        wr_addr       = '0;
        swp_ptr_nxt   = swp_ptr_r + IDX_W'(1);
        if (swp_ptr_r == LAST_IDX) begin
          swp_ptr_nxt   = '0;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{action: ACT_DONE, slot: 8'd0, short_isa: 1'b0};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/hbcd_checker.sv @@
// ----------------------------------------------------------------------------
// hbcd_checker
// Port-level checks for the code block directory, bound to the top level.
// ----------------------------------------------------------------------------
module hbcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input hbcd_pkg::in_item_t  in_item,
  input logic                out_valid,
  input hbcd_pkg::out_item_t out_item
);
  import hbcd_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("directory not busy after reset");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.kind == KIND_LOOKUP) |=> busy)
    else $error("lookup did not hold busy");

  a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.kind != KIND_LOOKUP) && (in_item.kind != KIND_INVAL) &&
    (in_item.kind != KIND_CLEAR)
    |=> out_valid && (out_item.action == ACT_DONE) && (out_item.slot == 8'd0))
    else $error("unused kind did not complete at once");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind hot_block_code_cache_directory_core hbcd_checker u_hbcd_checker (.*);
